// File: design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types and constants for the quoted-string decoder: the result entry,
// the job that carries up to four results from the front to the back, and the
// status codes.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // Default number of jobs the queue between front and back can hold.
   localparam int unsigned JSU_QUEUE_DEPTH = 4;

   // Most results one text byte can cause.
   localparam int unsigned JSU_MAX_RESULTS = 4;

   // Status codes carried on every result.
   localparam logic [2:0] STATUS_RUNNING   = 3'd0;
   localparam logic [2:0] STATUS_CLOSED    = 3'd1;
   localparam logic [2:0] STATUS_NO_QUOTE  = 3'd2;
   localparam logic [2:0] STATUS_BAD_ESC   = 3'd3;
   localparam logic [2:0] STATUS_BAD_HEX   = 3'd4;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd5;
   localparam logic [2:0] STATUS_UNTERM    = 3'd6;

   // One result as it leaves the block.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [2:0] status;
   } res_entry_type;

   // All results caused by one text byte; last_idx points at the final one.
   typedef struct packed {
      logic [1:0]                          last_idx;
      res_entry_type [JSU_MAX_RESULTS-1:0] entry;
   } job_type;

endpackage

// File: design/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Decodes one quoted JSON string from a byte stream into UTF-8 bytes and
// status results.
// ----------------------------------------------------------------------------
// Usage: the req channel carries one text byte per transaction, or an
// end-of-text marker. The decoder first expects an opening quote, then passes
// raw bytes, maps short escapes and turns \u escapes (with surrogate pairs)
// into one to four UTF-8 bytes. The rsp channel carries one result per
// transaction: a decoded byte or a status, with rsp_last flagging the final
// result caused by a text byte. A closing quote or any error returns the
// decoder to idle. A text byte causes zero to four results.
// Throughput: one text byte per cycle while each byte causes at most one
// result and the queue is not full; the result side moves one result per
// cycle while rsp_stall is low, a job's results one after the other. Each
// job is registered in the queue before its results are offered. The job
// queue (QUEUE_DEPTH jobs) absorbs the difference; when it is full req_stall
// rises. Reset clears the state machine and empties the queue. A stalled rsp
// transaction holds its payload; the front keeps taking bytes until the
// queue fills.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8
   import jsu_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = JSU_QUEUE_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic [2:0] rsp_status,
   output logic       rsp_last
);

   // Front to queue: one job per text byte that causes any result.
   logic    push;
   job_type push_job;
   logic    queue_full;

   // Queue to back: the oldest job and its release.
   job_type head_job;
   logic    head_valid;
   logic    pop;

   // The front end owns the string state machine and builds whole jobs, so
   // the escape and surrogate decisions are made once per text byte.
   jsu_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .queue_full      (queue_full),
      .push            (push),
      .push_job        (push_job)
   );

   // The queue decouples byte intake from the multi-cycle result output.
   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_job   (head_job),
      .head_valid (head_valid)
   );

   // The back end drives the result port straight from the queue head, which
   // is registered, so rsp_valid never depends on rsp_stall.
   jsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_job       (head_job),
      .head_valid     (head_valid),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

// File: design/jsu_front.sv
// ----------------------------------------------------------------------------
// JSON string unescape front end
// Accepts text bytes, runs the string/escape state machine and packs the
// results that each byte causes into one job for the queue.
// ----------------------------------------------------------------------------
module jsu_front
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   input  logic       queue_full,
   output logic       push,
   output job_type    push_job
);

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_U         = 8'h75;

   localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
   localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
   localparam logic [20:0] SUPPL_BASE    = 21'h10000;

   typedef enum logic [6:0] {
      PH_IDLE     = 7'b0000001,
      PH_STRING   = 7'b0000010,
      PH_ESC      = 7'b0000100,
      PH_HEX1     = 7'b0001000,
      PH_AFTERHI  = 7'b0010000,
      PH_HIBACKSL = 7'b0100000,
      PH_HEX2     = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   typedef struct packed {
      logic [1:0]      last_idx;
      logic [3:0][7:0] bytes;
   } utf8_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] value;
   } esc_map_type;

   function automatic hex_digit_type hex_digit(input logic [7:0] b);
      hex_digit_type r;
      r = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r.ok    = 1'b1;
         r.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r.ok    = 1'b1;
         r.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r.ok    = 1'b1;
         r.value = 4'(b - 8'h37);
      end
      return r;
   endfunction

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp <= 21'h7F) begin
         r.last_idx = 2'd0;
         r.bytes[0] = cp[7:0];
      end else if (cp <= 21'h7FF) begin
         r.last_idx = 2'd1;
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hFFFF) begin
         r.last_idx = 2'd2;
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         r.last_idx = 2'd3;
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

   function automatic esc_map_type escape_map(input logic [7:0] b);
      esc_map_type r;
      r.ok = 1'b1;
      unique case (b)
         CH_QUOTE:     r.value = CH_QUOTE;
         CH_BACKSLASH: r.value = CH_BACKSLASH;
         CH_SLASH:     r.value = CH_SLASH;
         CH_B:         r.value = 8'h08;
         CH_F:         r.value = 8'h0C;
         CH_N:         r.value = 8'h0A;
         CH_R:         r.value = 8'h0D;
         CH_T:         r.value = 8'h09;
         default: begin
            r.ok    = 1'b0;
            r.value = 8'h00;
         end
      endcase
      return r;
   endfunction

   function automatic res_entry_type byte_entry(input logic [7:0] b);
      res_entry_type r;
      r.out_byte   = b;
      r.byte_valid = 1'b1;
      r.status     = STATUS_RUNNING;
      return r;
   endfunction

   function automatic res_entry_type status_entry(input logic [2:0] s);
      res_entry_type r;
      r.out_byte   = 8'h00;
      r.byte_valid = 1'b0;
      r.status     = s;
      return r;
   endfunction

   phase_type     phase_ff, phase_in;
   logic [15:0]   hex_acc_ff, hex_acc_in;
   logic [1:0]    digit_count_ff, digit_count_in;
   logic [15:0]   held_ff, held_in;
   logic          bad_seen_ff, bad_seen_in;

   logic          req_accept;
   logic [7:0]    b;
   logic          eot;
   hex_digit_type dig;
   logic [15:0]   acc_next;
   logic          bad_next;
   logic          fourth;
   esc_map_type   esc;
   logic          pre_en;
   logic          cp_en;
   logic [20:0]   cp_val;
   logic          tail_en;
   res_entry_type tail_entry;
   utf8_type      held_enc;
   utf8_type      cp_enc;
   job_type       job;

   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;
   assign b          = req_text_byte;
   assign eot        = req_end_of_text;
   assign dig        = hex_digit(b);
   assign acc_next   = {hex_acc_ff[11:0], dig.value};
   assign bad_next   = bad_seen_ff | ~dig.ok;
   assign fourth     = (digit_count_ff == 2'd3);
   assign esc        = escape_map(b);

   always_comb begin
      phase_in       = phase_ff;
      hex_acc_in     = hex_acc_ff;
      digit_count_in = digit_count_ff;
      held_in        = held_ff;
      bad_seen_in    = bad_seen_ff;
      pre_en         = 1'b0;
      cp_en          = 1'b0;
      cp_val         = '0;
      tail_en        = 1'b0;
      tail_entry     = status_entry(STATUS_RUNNING);

      if (req_accept) begin
         unique case (phase_ff)
            PH_STRING: begin
               if (eot) begin
                  tail_en    = 1'b1;
                  tail_entry = status_entry(STATUS_UNTERM);
                  phase_in   = PH_IDLE;
               end else if (b == CH_QUOTE) begin
                  tail_en    = 1'b1;
                  tail_entry = status_entry(STATUS_CLOSED);
                  phase_in   = PH_IDLE;
               end else if (b == CH_BACKSLASH) begin
                  phase_in = PH_ESC;
               end else begin
                  tail_en    = 1'b1;
                  tail_entry = byte_entry(b);
               end
            end
            PH_ESC: begin
               if (eot) begin
                  tail_en    = 1'b1;
                  tail_entry = status_entry(STATUS_UNTERM);
                  phase_in   = PH_IDLE;
               end else if (b == CH_U) begin
                  phase_in       = PH_HEX1;
                  hex_acc_in     = '0;
                  digit_count_in = '0;
                  bad_seen_in    = 1'b0;
               end else if (esc.ok) begin
                  tail_en    = 1'b1;
                  tail_entry = byte_entry(esc.value);
                  phase_in   = PH_STRING;
               end else begin
                  tail_en    = 1'b1;
                  tail_entry = status_entry(STATUS_BAD_ESC);
                  phase_in   = PH_IDLE;
               end
            end
            PH_HEX1: begin
               if (eot) begin
                  tail_en    = 1'b1;
                  tail_entry = status_entry(STATUS_TRUNCATED);
                  phase_in   = PH_IDLE;
               end else begin
                  hex_acc_in     = acc_next;
                  digit_count_in = digit_count_ff + 2'd1;
                  bad_seen_in    = bad_next;
                  if (fourth) begin
                     if (bad_next) begin
                        tail_en    = 1'b1;
                        tail_entry = status_entry(STATUS_BAD_HEX);
                        phase_in   = PH_IDLE;
                     end else if (acc_next >= HIGH_SURR_MIN && acc_next <= HIGH_SURR_MAX) begin
                        held_in  = acc_next;
                        phase_in = PH_AFTERHI;
                     end else begin
                        cp_en    = 1'b1;
                        cp_val   = {5'b0, acc_next};
                        phase_in = PH_STRING;
                     end
                  end
               end
            end
            PH_AFTERHI: begin
               if (!eot && b == CH_BACKSLASH) begin
                  phase_in = PH_HIBACKSL;
               end else begin
                  // The waiting high surrogate goes out on its own first.
                  pre_en   = 1'b1;
                  held_in  = '0;
                  phase_in = PH_STRING;
                  if (eot) begin
                     tail_en    = 1'b1;
                     tail_entry = status_entry(STATUS_UNTERM);
                     phase_in   = PH_IDLE;
                  end else if (b == CH_QUOTE) begin
                     tail_en    = 1'b1;
                     tail_entry = status_entry(STATUS_CLOSED);
                     phase_in   = PH_IDLE;
                  end else begin
                     tail_en    = 1'b1;
                     tail_entry = byte_entry(b);
                  end
               end
            end
            PH_HIBACKSL: begin
               if (!eot && b == CH_U) begin
                  phase_in       = PH_HEX2;
                  hex_acc_in     = '0;
                  digit_count_in = '0;
                  bad_seen_in    = 1'b0;
               end else begin
                  pre_en   = 1'b1;
                  held_in  = '0;
                  phase_in = PH_STRING;
                  tail_en  = 1'b1;
                  if (eot) begin
                     tail_entry = status_entry(STATUS_UNTERM);
                     phase_in   = PH_IDLE;
                  end else if (esc.ok) begin
                     tail_entry = byte_entry(esc.value);
                  end else begin
                     tail_entry = status_entry(STATUS_BAD_ESC);
                     phase_in   = PH_IDLE;
                  end
               end
            end
            PH_HEX2: begin
               if (eot) begin
                  tail_en    = 1'b1;
                  tail_entry = status_entry(STATUS_TRUNCATED);
                  phase_in   = PH_IDLE;
               end else begin
                  hex_acc_in     = acc_next;
                  digit_count_in = digit_count_ff + 2'd1;
                  bad_seen_in    = bad_next;
                  if (fourth) begin
                     if (bad_next) begin
                        tail_en    = 1'b1;
                        tail_entry = status_entry(STATUS_BAD_HEX);
                        phase_in   = PH_IDLE;
                     end else begin
                        cp_en = 1'b1;
                        if (acc_next >= LOW_SURR_MIN && acc_next <= LOW_SURR_MAX) begin
                           cp_val = SUPPL_BASE + {1'b0, held_ff[9:0], acc_next[9:0]};
                        end else begin
                           // Second value is not a low surrogate: it is dropped.
                           cp_val = {5'b0, held_ff};
                        end
                        held_in    = '0;
                        hex_acc_in = '0;
                        phase_in   = PH_STRING;
                     end
                  end
               end
            end
            default: begin
               // Idle, and any code that is not a valid state.
               if (!eot && b == CH_QUOTE) begin
                  phase_in = PH_STRING;
               end else begin
                  tail_en    = 1'b1;
                  tail_entry = status_entry(STATUS_NO_QUOTE);
                  phase_in   = PH_IDLE;
               end
            end
         endcase

         // Every return to idle clears the working registers.
         if (phase_in == PH_IDLE) begin
            hex_acc_in     = '0;
            digit_count_in = '0;
            held_in        = '0;
            bad_seen_in    = 1'b0;
         end
      end
   end

   assign held_enc = utf8_encode({5'b0, held_ff});
   assign cp_enc   = utf8_encode(cp_val);

   always_comb begin
      job = '0;
      if (cp_en) begin
         job.last_idx = cp_enc.last_idx;
         for (int i = 0; i < 4; i++) begin
            job.entry[i] = byte_entry(cp_enc.bytes[i]);
         end
      end else if (pre_en) begin
         // A held high surrogate always encodes as three bytes.
         job.entry[0] = byte_entry(held_enc.bytes[0]);
         job.entry[1] = byte_entry(held_enc.bytes[1]);
         job.entry[2] = byte_entry(held_enc.bytes[2]);
         job.entry[3] = tail_entry;
         job.last_idx = tail_en ? 2'd3 : 2'd2;
      end else begin
         job.entry[0] = tail_entry;
         job.last_idx = 2'd0;
      end
   end

   assign push     = req_accept && (cp_en || pre_en || tail_en);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         hex_acc_ff     <= '0;
         digit_count_ff <= '0;
         held_ff        <= '0;
         bad_seen_ff    <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         hex_acc_ff     <= hex_acc_in;
         digit_count_ff <= digit_count_in;
         held_ff        <= held_in;
         bad_seen_ff    <= bad_seen_in;
      end
   end

endmodule

// File: design/jsu_queue.sv
// ----------------------------------------------------------------------------
// JSON string unescape job queue
// A small circular buffer of jobs between the front end and the result
// serializer, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module jsu_queue
   import jsu_pkg::*;
#(
   parameter int unsigned DEPTH = JSU_QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head_job,
   output logic    head_valid
);

   // DEPTH must be at least two.
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: design/jsu_back.sv
// ----------------------------------------------------------------------------
// JSON string unescape result serializer
// Walks the results of the job at the head of the queue, one result per
// transaction, and releases the job after its final result.
// ----------------------------------------------------------------------------
module jsu_back
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  job_type    head_job,
   input  logic       head_valid,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic [2:0] rsp_status,
   output logic       rsp_last
);

   logic [1:0]    idx_ff, idx_in;
   res_entry_type cur;
   logic          at_last;
   logic          rsp_accept;

   assign cur        = head_job.entry[idx_ff];
   assign at_last    = (idx_ff == head_job.last_idx);
   assign rsp_accept = head_valid && !rsp_stall;
   assign pop        = rsp_accept && at_last;

   assign rsp_valid      = head_valid;
   assign rsp_out_byte   = cur.out_byte;
   assign rsp_byte_valid = cur.byte_valid;
   assign rsp_status     = cur.status;
   assign rsp_last       = at_last;

   always_comb begin
      idx_in = idx_ff;
      if (rsp_accept) begin
         idx_in = at_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// File: sim/json_string_unescape_utf8_test.sv
// ----------------------------------------------------------------------------
// JSON string unescape testbench
// Feeds quoted JSON strings byte by byte into the decoder, first from a short
// table of hand-picked bytes and then from randomly built strings. Every
// result transaction is compared against a behavioral decoder kept in this
// module, or a typed row's own result. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_test;
   import jsu_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 320;
   localparam int DRAIN_CYCLES   = 20;
   localparam int MAX_REPORTS    = 40;

   // Characters the decoder treats specially.
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] ESC_B      = "b";
   localparam logic [7:0] ESC_F      = "f";
   localparam logic [7:0] ESC_N      = "n";
   localparam logic [7:0] ESC_R      = "r";
   localparam logic [7:0] ESC_T      = "t";
   localparam logic [7:0] ESC_U      = "u";
   localparam logic [7:0] CH_0       = "0";
   localparam logic [7:0] CH_9       = "9";
   localparam logic [7:0] CH_LOW_A   = "a";
   localparam logic [7:0] CH_LOW_F   = "f";
   localparam logic [7:0] CH_UP_A    = "A";
   localparam logic [7:0] CH_UP_F    = "F";

   typedef enum logic [2:0] {
      DEC_IDLE,
      DEC_STRING,
      DEC_ESCAPE,
      DEC_HEX1,
      DEC_AFTER_HIGH,
      DEC_HIGH_BSLASH,
      DEC_HEX2
   } dec_phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [2:0] status;
      logic       last;
   } decoded_type;

   // One text byte to send; typed rows carry their single expected result.
   typedef struct {
      logic [7:0] text_byte;
      logic       eot;
      bit         typed;
      logic [7:0] t_out;
      logic       t_valid;
      logic [2:0] t_status;
   } text_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic [2:0] rsp_status;
   logic       rsp_last;

   text_item_type req_row;
   text_item_type directed_rows[$];
   text_item_type string_bytes[$];
   decoded_type   decoded_due[$];

   // Decoder state mirrored from the block.
   dec_phase_type m_phase = DEC_IDLE;
   logic [15:0]   m_accum = 16'h0000;
   logic [1:0]    m_digits = 2'd0;
   logic [15:0]   m_high = 16'h0000;
   bit            m_bad = 1'b0;
   decoded_type   pend [0:JSU_MAX_RESULTS-1];
   int            pend_n;

   bit calm = 1'b0;
   int mismatches = 0;
   int idle_cycles = 0;
   int items_taken = 0;
   int results_seen = 0;
   int strings_closed = 0;
   int error_ends = 0;

   always #1 clock = ~clock;

   json_string_unescape_utf8 dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   task report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("MISMATCH: %s", what);
      end
   endtask

   // ------------------------------------------------------------------------
   // Behavioral decoder
   // ------------------------------------------------------------------------
   function void emit(input logic [7:0] b, input logic v, input logic [2:0] st);
      if (pend_n < JSU_MAX_RESULTS) begin
         pend[pend_n] = '{out_byte: b, byte_valid: v, status: st, last: 1'b0};
         pend_n++;
      end
   endfunction

   function void emit_byte(input logic [7:0] b);
      emit(b, 1'b1, STATUS_RUNNING);
   endfunction

   function void clear_work();
      m_accum = 16'h0000;
      m_digits = 2'd0;
      m_high = 16'h0000;
      m_bad = 1'b0;
   endfunction

   function void finish_string(input logic [2:0] st);
      emit(8'h00, 1'b0, st);
      m_phase = DEC_IDLE;
      clear_work();
   endfunction

   function void emit_utf8(input logic [20:0] cp);
      if (cp <= 21'h7F) begin
         emit_byte(cp[7:0]);
      end else if (cp <= 21'h7FF) begin
         emit_byte(8'hC0 | cp[10:6]);
         emit_byte(8'h80 | cp[5:0]);
      end else if (cp <= 21'hFFFF) begin
         emit_byte(8'hE0 | cp[15:12]);
         emit_byte(8'h80 | cp[11:6]);
         emit_byte(8'h80 | cp[5:0]);
      end else begin
         emit_byte(8'hF0 | cp[20:18]);
         emit_byte(8'h80 | cp[17:12]);
         emit_byte(8'h80 | cp[11:6]);
         emit_byte(8'h80 | cp[5:0]);
      end
   endfunction

   function void string_char(input logic [7:0] b);
      if (b == CH_QUOTE) begin
         finish_string(STATUS_CLOSED);
      end else if (b == CH_BSLASH) begin
         m_phase = DEC_ESCAPE;
      end else begin
         emit_byte(b);
      end
   endfunction

   function void escape_char(input logic [7:0] b);
      logic [7:0] mapped;
      mapped = b;
      case (b)
         CH_QUOTE, CH_BSLASH, CH_SLASH: mapped = b;
         ESC_B: mapped = 8'h08;
         ESC_F: mapped = 8'h0C;
         ESC_N: mapped = 8'h0A;
         ESC_R: mapped = 8'h0D;
         ESC_T: mapped = 8'h09;
         ESC_U: begin
            m_phase = DEC_HEX1;
            m_accum = 16'h0000;
            m_digits = 2'd0;
            m_bad = 1'b0;
            return;
         end
         default: begin
            finish_string(STATUS_BAD_ESC);
            return;
         end
      endcase
      emit_byte(mapped);
      m_phase = DEC_STRING;
   endfunction

   // A bad digit counts as zero and is only flagged; true on the fourth digit.
   function bit take_digit(input logic [7:0] b);
      logic [3:0] d;
      d = 4'h0;
      if (b >= CH_0 && b <= CH_9) begin
         d = 4'(b - CH_0);
      end else if (b >= CH_LOW_A && b <= CH_LOW_F) begin
         d = 4'(b - CH_LOW_A + 8'd10);
      end else if (b >= CH_UP_A && b <= CH_UP_F) begin
         d = 4'(b - CH_UP_A + 8'd10);
      end else begin
         m_bad = 1'b1;
      end
      m_accum = {m_accum[11:0], d};
      if (m_digits == 2'd3) begin
         m_digits = 2'd0;
         return 1'b1;
      end
      m_digits++;
      return 1'b0;
   endfunction

   // Works out the results of one text transaction into pend[0 .. pend_n-1].
   function void decode_text_byte(input logic [7:0] b, input logic eot);
      int cp;
      pend_n = 0;
      case (m_phase)
         DEC_STRING: begin
            if (eot) finish_string(STATUS_UNTERM);
            else string_char(b);
         end
         DEC_ESCAPE: begin
            if (eot) finish_string(STATUS_UNTERM);
            else escape_char(b);
         end
         DEC_HEX1: begin
            if (eot) begin
               finish_string(STATUS_TRUNCATED);
            end else if (take_digit(b)) begin
               if (m_bad) begin
                  finish_string(STATUS_BAD_HEX);
               end else if (m_accum >= 16'hD800 && m_accum <= 16'hDBFF) begin
                  m_high = m_accum;
                  m_phase = DEC_AFTER_HIGH;
               end else begin
                  emit_utf8({5'd0, m_accum});
                  m_phase = DEC_STRING;
               end
            end
         end
         DEC_AFTER_HIGH: begin
            // Only a backslash keeps the high surrogate waiting.
            if (eot || b != CH_BSLASH) begin
               emit_utf8({5'd0, m_high});
               m_high = 16'h0000;
               m_phase = DEC_STRING;
               if (eot) finish_string(STATUS_UNTERM);
               else string_char(b);
            end else begin
               m_phase = DEC_HIGH_BSLASH;
            end
         end
         DEC_HIGH_BSLASH: begin
            if (!eot && b == ESC_U) begin
               m_phase = DEC_HEX2;
               m_accum = 16'h0000;
               m_digits = 2'd0;
               m_bad = 1'b0;
            end else begin
               emit_utf8({5'd0, m_high});
               m_high = 16'h0000;
               m_phase = DEC_STRING;
               if (eot) finish_string(STATUS_UNTERM);
               else escape_char(b);
            end
         end
         DEC_HEX2: begin
            if (eot) begin
               finish_string(STATUS_TRUNCATED);
            end else if (take_digit(b)) begin
               if (m_bad) begin
                  finish_string(STATUS_BAD_HEX);
               end else begin
                  // A low surrogate pairs up; anything else drops, leaving the high one.
                  if (m_accum >= 16'hDC00 && m_accum <= 16'hDFFF) begin
                     cp = 'h10000 + ((int'(m_high) - 'hD800) << 10)
                          + (int'(m_accum) - 'hDC00);
                     emit_utf8(cp[20:0]);
                  end else begin
                     emit_utf8({5'd0, m_high});
                  end
                  m_high = 16'h0000;
                  m_accum = 16'h0000;
                  m_phase = DEC_STRING;
               end
            end
         end
         default: begin
            if (!eot && b == CH_QUOTE) begin
               m_phase = DEC_STRING;
               clear_work();
            end else begin
               finish_string(STATUS_NO_QUOTE);
            end
         end
      endcase
      if (pend_n > 0) pend[pend_n-1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------------
   function text_item_type plain_item(input logic [7:0] b, input logic eot);
      plain_item = '{text_byte: b, eot: eot, typed: 1'b0, t_out: 8'h00,
                     t_valid: 1'b0, t_status: STATUS_RUNNING};
   endfunction

   function text_item_type typed_item(input logic [7:0] b, input logic eot,
                                      input logic [7:0] out, input logic v,
                                      input logic [2:0] st);
      typed_item = '{text_byte: b, eot: eot, typed: 1'b1, t_out: out,
                     t_valid: v, t_status: st};
   endfunction

   function void add_row(input text_item_type row);
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function logic [7:0] any_raw();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == CH_QUOTE || b == CH_BSLASH) b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   function logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return CH_0 + n;
      if ($urandom_range(0, 1)) return CH_LOW_A + n - 8'd10;
      return CH_UP_A + n - 8'd10;
   endfunction

   function logic [7:0] non_hex_char();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while ((b >= CH_0 && b <= CH_9) || (b >= CH_LOW_A && b <= CH_LOW_F) ||
             (b >= CH_UP_A && b <= CH_UP_F)) begin
         b = 8'($urandom_range(0, 255));
      end
      return b;
   endfunction

   function logic [7:0] short_escape();
      case ($urandom_range(0, 7))
         0: return CH_QUOTE;
         1: return CH_BSLASH;
         2: return CH_SLASH;
         3: return ESC_B;
         4: return ESC_F;
         5: return ESC_N;
         6: return ESC_R;
         default: return ESC_T;
      endcase
   endfunction

   function logic [7:0] bad_escape_char();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == ESC_B ||
             b == ESC_F || b == ESC_N || b == ESC_R || b == ESC_T || b == ESC_U) begin
         b = 8'($urandom_range(0, 255));
      end
      return b;
   endfunction

   // A \u value that is not a high surrogate, spread over the UTF-8 lengths.
   function logic [15:0] draw_code();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 'h7F));
         1: return 16'($urandom_range('h80, 'h7FF));
         2: return 16'($urandom_range('h800, 'hD7FF));
         3: return 16'($urandom_range('hE000, 'hFFFF));
         4: return 16'($urandom_range('hDC00, 'hDFFF));
         default: begin
            case ($urandom_range(0, 5))
               0: return 16'h0000;
               1: return 16'h007F;
               2: return 16'h0080;
               3: return 16'h07FF;
               4: return 16'h0800;
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   function void push_text(input logic [7:0] b);
      string_bytes.insert(string_bytes.size(), plain_item(b, 1'b0));
   endfunction

   function void push_eot();
      string_bytes.insert(string_bytes.size(),
                          plain_item(8'($urandom_range(0, 255)), 1'b1));
   endfunction

   function void add_hex_escape(input logic [15:0] v, input bit corrupt);
      int bad_pos;
      bad_pos = corrupt ? $urandom_range(0, 3) : -1;
      push_text(CH_BSLASH);
      push_text(ESC_U);
      for (int i = 3; i >= 0; i--) begin
         push_text((i == bad_pos) ? non_hex_char() : hex_char(v[i*4 +: 4]));
      end
   endfunction

   // Escape cut off by end of text: right after the backslash, or after \u and zero to three digits.
   function void add_truncated(input bit in_digits);
      int k;
      push_text(CH_BSLASH);
      if (in_digits) begin
         push_text(ESC_U);
         k = $urandom_range(0, 3);
         for (int i = 0; i < k; i++) push_text(hex_char(4'($urandom_range(0, 15))));
      end
      push_eot();
   endfunction

   // What follows a high surrogate decides whether it pairs, drops or stands alone.
   function bit add_surrogate_piece();
      add_hex_escape(16'($urandom_range('hD800, 'hDBFF)), 1'b0);
      case ($urandom_range(0, 10))
         0, 1, 2: add_hex_escape(16'($urandom_range('hDC00, 'hDFFF)), 1'b0);
         3: add_hex_escape(16'($urandom_range(0, 'hFFFF)), 1'b0);
         4: push_text(any_raw());
         5: begin
            push_text(CH_BSLASH);
            push_text(short_escape());
         end
         6: begin
            push_text(CH_BSLASH);
            push_text(bad_escape_char());
            return 1'b1;
         end
         7: begin
            push_eot();
            return 1'b1;
         end
         8: begin
            add_hex_escape(16'($urandom_range(0, 'hFFFF)), 1'b1);
            return 1'b1;
         end
         9: begin
            add_truncated(1'($urandom_range(0, 1)));
            return 1'b1;
         end
         default: begin
            push_text(CH_QUOTE);
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   // One piece of string content; true when the piece already ended the string.
   function bit add_piece();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         push_text(any_raw());
      end else if (pick < 55) begin
         push_text(CH_BSLASH);
         push_text(short_escape());
      end else if (pick < 75) begin
         add_hex_escape(draw_code(), 1'b0);
      end else if (pick < 90) begin
         return add_surrogate_piece();
      end else if (pick < 94) begin
         push_text(CH_BSLASH);
         push_text(bad_escape_char());
         return 1'b1;
      end else if (pick < 97) begin
         add_hex_escape(draw_code(), 1'b1);
         return 1'b1;
      end else begin
         add_truncated(1'($urandom_range(0, 1)));
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Mostly well-formed strings with random content, some noise before them.
   function void build_string();
      int pieces;
      bit ended;
      string_bytes.delete();
      if ($urandom_range(0, 6) == 0) begin
         if ($urandom_range(0, 1)) push_eot();
         else push_text(any_raw());
      end
      push_text(CH_QUOTE);
      pieces = $urandom_range(0, 6);
      ended = 1'b0;
      for (int i = 0; i < pieces && !ended; i++) ended = add_piece();
      if (!ended) begin
         if ($urandom_range(0, 9) < 8) push_text(CH_QUOTE);
         else push_eot();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------------
   task send_item(input text_item_type it);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= it.text_byte;
      req_end_of_text <= it.eot;
      req_row <= it;
      forever begin
         @(posedge clock);
         if (req_valid && !req_stall) break;
      end
   endtask

   // Holds the sender off until every expected result has arrived.
   task wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (decoded_due.size() != 0);
   endtask

   initial begin : rsp_pacing
      int n;
      forever begin
         n = calm ? 0 : $urandom_range(0, 5);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // ------------------------------------------------------------------------
   // Checker: compares results, runs the decoder on accepted text, watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      decoded_type want;
      bit moved;
      moved = 1'b0;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            results_seen++;
            if (rsp_status == STATUS_CLOSED) strings_closed++;
            else if (rsp_status != STATUS_RUNNING) error_ends++;
            if (decoded_due.size() == 0) begin
               report_mismatch($sformatf(
                  "result %0d arrived with none pending: byte %02h valid %b status %0d last %b",
                  results_seen, rsp_out_byte, rsp_byte_valid, rsp_status, rsp_last));
            end else begin
               want = decoded_due.pop_front();
               if (rsp_out_byte !== want.out_byte || rsp_byte_valid !== want.byte_valid ||
                   rsp_status !== want.status || rsp_last !== want.last) begin
                  report_mismatch($sformatf(
                     "result %0d: got byte %02h valid %b status %0d last %b, want %02h %b %0d %b",
                     results_seen, rsp_out_byte, rsp_byte_valid, rsp_status, rsp_last,
                     want.out_byte, want.byte_valid, want.status, want.last));
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            items_taken++;
            // Typed rows still run through the decoder to keep its state in step.
            decode_text_byte(req_text_byte, req_end_of_text);
            if (req_row.typed) begin
               decoded_due.insert(decoded_due.size(),
                                  '{out_byte: req_row.t_out, byte_valid: req_row.t_valid,
                                    status: req_row.t_status, last: 1'b1});
            end else begin
               for (int i = 0; i < pend_n; i++) begin
                  decoded_due.insert(decoded_due.size(), pend[i]);
               end
            end
         end
         if (moved) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("CHECK FAILED");
               $finish;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : sequencer
      int random_sent;
      int strings_built;
      int n_directed;

      // End of text while idle, then the two raw extremes and a bad
      // escape, a surrogate pair to the top code point, a bad hex digit, text
      // ending inside \u, a closed string and an unterminated one.
      add_row(typed_item(8'hFF, 1'b1, 8'h00, 1'b0, STATUS_NO_QUOTE));
      add_row(plain_item(CH_QUOTE, 1'b0));
      add_row(typed_item(8'hFF, 1'b0, 8'hFF, 1'b1, STATUS_RUNNING));
      add_row(typed_item(8'h00, 1'b0, 8'h00, 1'b1, STATUS_RUNNING));
      add_row(plain_item(CH_BSLASH, 1'b0));
      add_row(typed_item("q", 1'b0, 8'h00, 1'b0, STATUS_BAD_ESC));
      add_row(plain_item(CH_QUOTE, 1'b0));
      add_row(plain_item(CH_BSLASH, 1'b0));
      add_row(plain_item(ESC_U, 1'b0));
      add_row(plain_item("D", 1'b0));
      add_row(plain_item("b", 1'b0));
      add_row(plain_item("f", 1'b0));
      add_row(plain_item("F", 1'b0));
      add_row(plain_item(CH_BSLASH, 1'b0));
      add_row(plain_item(ESC_U, 1'b0));
      add_row(plain_item("D", 1'b0));
      add_row(plain_item("F", 1'b0));
      add_row(plain_item("f", 1'b0));
      add_row(plain_item("F", 1'b0));
      add_row(plain_item(CH_BSLASH, 1'b0));
      add_row(plain_item(ESC_U, 1'b0));
      add_row(plain_item("g", 1'b0));
      add_row(plain_item("0", 1'b0));
      add_row(plain_item("0", 1'b0));
      add_row(typed_item("0", 1'b0, 8'h00, 1'b0, STATUS_BAD_HEX));
      add_row(plain_item(CH_QUOTE, 1'b0));
      add_row(plain_item(CH_BSLASH, 1'b0));
      add_row(plain_item(ESC_U, 1'b0));
      add_row(typed_item(8'h00, 1'b1, 8'h00, 1'b0, STATUS_TRUNCATED));
      add_row(plain_item(CH_QUOTE, 1'b0));
      add_row(typed_item(CH_QUOTE, 1'b0, 8'h00, 1'b0, STATUS_CLOSED));
      add_row(plain_item(CH_QUOTE, 1'b0));
      add_row(typed_item(8'h5A, 1'b1, 8'h00, 1'b0, STATUS_UNTERM));
      n_directed = directed_rows.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_item(directed_rows[i]);
      wait_drained();

      random_sent = 0;
      strings_built = 0;
      while (random_sent < RANDOM_ITEMS) begin
         build_string();
         strings_built++;
         calm = ($urandom_range(0, 3) == 0);
         if (strings_built % 12 == 6) wait_drained();
         foreach (string_bytes[i]) begin
            send_item(string_bytes[i]);
            random_sent++;
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d text bytes (%0d table rows, %0d random strings); checked %0d results.",
               items_taken, n_directed, strings_built, results_seen);
      $display("Strings closed by a quote: %0d; ended by an error or missing quote: %0d.",
               strings_closed, error_ends);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/jsu_pkg.sv
design/jsu_front.sv
design/jsu_queue.sv
design/jsu_back.sv
design/json_string_unescape_utf8.sv
sim/json_string_unescape_utf8_test.sv
